>>> src/lpef_pkg.sv
// lpef_pkg: constants, types and elaboration-time functions of the pixel encoder
// no dependencies; used by every other file of the block

package lpef_pkg;

  localparam int unsigned SRGB_INDEX_BITS_DEF = 16;
  localparam int unsigned WORD_W              = 32;
  localparam int unsigned MANT_W              = 24;
  localparam int unsigned CODE_W              = 8;
  localparam int unsigned SH_W                = 5;
  localparam int unsigned NUM_CHAN            = 4;
  localparam int unsigned ALPHA_CHAN          = 3;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_OUTPUT_MODE = '0;

  localparam int unsigned ARITH_STAGES = 3;
  localparam int unsigned SRCH_STAGES  = 4;
  localparam int unsigned NUM_STAGES   = ARITH_STAGES + SRCH_STAGES;

  localparam logic [WORD_W-1:0] FLOAT_ONE  = 32'h3F80_0000;
  localparam logic [WORD_W-1:0] HDR_MAX    = 32'h477F_E000;
  localparam logic [CODE_W-1:0] UNORM_MAX  = 8'd255;
  localparam logic [CODE_W-1:0] NORMAL_MID = 8'd128;

  // float exponent to right shift: |x| = m / 2^s
  localparam logic [7:0] EXP_SHIFT_BASE = 8'd150;
  localparam logic [7:0] DENORM_SHIFT   = 8'd149;
  localparam logic [7:0] SHIFT_MIN      = 8'd24;
  localparam logic [7:0] SHIFT_CLIP     = 8'd42;

  // srgb linear segment and curve thresholds
  localparam longint unsigned SRGB_LIN_NUM      = 32946;
  localparam longint unsigned SRGB_LIN_HALF     = 5;
  localparam longint unsigned SRGB_LIN_SCALE    = 10;
  localparam longint unsigned SRGB_KNEE_NUM     = 31308;
  localparam longint unsigned SRGB_KNEE_DEN     = 10000000;
  localparam int unsigned     SRGB_THR_DEN      = 53805;
  localparam int unsigned     SRGB_THR_STEP     = 200;
  localparam int unsigned     SRGB_THR_OFS      = 2705;
  localparam int unsigned     SRGB_IDX_POW      = 5;
  localparam int unsigned     SRGB_CURVE_POW    = 12;
  localparam int unsigned     SRGB_SEARCH_ITERS = 18;

  typedef enum logic [1:0] {
    MODE_LINEAR = 2'd0,
    MODE_SRGB   = 2'd1,
    MODE_NORMAL = 2'd2,
    MODE_HDR    = 2'd3
  } mode_e;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              srgb;
  } chan_t;

  typedef logic [16:0]  thr_t;
  typedef thr_t         thr_arr_t [256];
  typedef logic [287:0] big_t;

  // smallest index i with i^5 * 53805^12 >= n^5 * (200k + 2705)^12
  function automatic thr_arr_t srgb_thresholds(input int unsigned bits);
    thr_arr_t    thr;
    big_t        rhs;
    big_t        lhs;
    big_t        curve;
    thr_t        lo;
    thr_t        hi;
    thr_t        mid;
    int unsigned n;
    n = (32'd1 << bits) - 32'd1;
    curve = big_t'(1);
    for (int j = 0; j < SRGB_CURVE_POW; j++) begin
      curve = curve * big_t'(SRGB_THR_DEN);
    end
    thr[0] = '0;
    for (int k = 1; k < 256; k++) begin
      rhs = big_t'(1);
      for (int j = 0; j < SRGB_IDX_POW; j++) begin
        rhs = rhs * big_t'(n);
      end
      for (int j = 0; j < SRGB_CURVE_POW; j++) begin
        rhs = rhs * big_t'(SRGB_THR_STEP * k + SRGB_THR_OFS);
      end
      lo = '0;
      hi = thr_t'(n + 1);
      for (int it = 0; it < SRGB_SEARCH_ITERS; it++) begin
        if (lo < hi) begin
          mid = lo + ((hi - lo) >> 1);
          lhs = curve;
          for (int j = 0; j < SRGB_IDX_POW; j++) begin
            lhs = lhs * big_t'(mid);
          end
          if (lhs >= rhs) begin
            hi = mid;
          end else begin
            lo = mid + thr_t'(1);
          end
        end
      end
      thr[k] = lo;
    end
    return thr;
  endfunction

endpackage

>>> src/lpef_if.sv
// lpef_in_if / lpef_out_if: valid-ready pixel channels of the encoder
// depends on lpef_pkg

interface lpef_in_if;
  import lpef_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] red_in;
  logic [WORD_W-1:0] green_in;
  logic [WORD_W-1:0] blue_in;
  logic [WORD_W-1:0] alpha_in;
  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface lpef_out_if;
  import lpef_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] red_out;
  logic [WORD_W-1:0] green_out;
  logic [WORD_W-1:0] blue_out;
  logic [WORD_W-1:0] alpha_out;
  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

>>> src/linear_pixel_to_encoder_format.sv
// linear_pixel_to_encoder_format: top level of the rgba pixel encoder
// depends on lpef_pkg, lpef_if, lpef_chan_arith and lpef_srgb_search

// Takes one linear RGBA pixel (four single-precision bit patterns) per clock while
// the output is not stalled, and returns it as unorm8 codes (linear, sRGB or
// normal map) or as HDR-clamped float bits, chosen by the output_mode register at
// byte address 0 of the APB port. A request passes from acceptance to a valid
// result through the three arithmetic stages (decode, scale multiply, round) and
// four sRGB search stages of two threshold steps each. Each stage holds its own
// valid bit, so bubbles are squeezed out under back-pressure.
// Write output_mode only while no pixel is in flight.

module linear_pixel_to_encoder_format #(
  parameter int unsigned SRGB_INDEX_BITS = lpef_pkg::SRGB_INDEX_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  lpef_in_if.sink                        pix_i,
  lpef_out_if.source                     pix_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpef_pkg::PADDR_W-1:0]   paddr,
  input  logic [lpef_pkg::PDATA_W-1:0]   pwdata,
  output logic [lpef_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import lpef_pkg::*;

  localparam int unsigned LAST = NUM_STAGES - 1;

  mode_e                mode_q;
  logic                 cfg_wr;
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] v_d;
  logic [NUM_STAGES-1:0] rdy;
  logic [WORD_W-1:0]    in_word  [NUM_CHAN];
  logic [WORD_W-1:0]    out_word [NUM_CHAN];
  chan_t                mid_chan [NUM_CHAN];

  // config port
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_OUTPUT_MODE);
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_OUTPUT_MODE) ? PDATA_W'(mode_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LINEAR;
    end else if (cfg_wr) begin
      mode_q <= mode_e'(pwdata[1:0]);
    end
  end

  // stage valids and per-stage ready
  assign rdy[LAST] = !v_q[LAST] || pix_o.ready;
  for (genvar k = 0; k < LAST; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  assign v_d[0] = rdy[0] ? pix_i.valid : v_q[0];
  for (genvar k = 1; k < NUM_STAGES; k++) begin : g_vld
    assign v_d[k] = rdy[k] ? v_q[k-1] : v_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign pix_i.ready = rdy[0];
  assign pix_o.valid = v_q[LAST];

  assign in_word[0] = pix_i.red_in;
  assign in_word[1] = pix_i.green_in;
  assign in_word[2] = pix_i.blue_in;
  assign in_word[3] = pix_i.alpha_in;

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    lpef_chan_arith #(
      .SRGB_INDEX_BITS (SRGB_INDEX_BITS)
    ) u_arith (
      .clk_i   (clk_i),
      .en_i    (rdy[ARITH_STAGES-1:0]),
      .mode_i  (mode_q),
      .alpha_i (1'(c == ALPHA_CHAN)),
      .word_i  (in_word[c]),
      .chan_o  (mid_chan[c])
    );

    lpef_srgb_search #(
      .SRGB_INDEX_BITS (SRGB_INDEX_BITS)
    ) u_search (
      .clk_i  (clk_i),
      .en_i   (rdy[NUM_STAGES-1:ARITH_STAGES]),
      .chan_i (mid_chan[c]),
      .word_o (out_word[c])
    );
  end

  assign pix_o.red_out   = out_word[0];
  assign pix_o.green_out = out_word[1];
  assign pix_o.blue_out  = out_word[2];
  assign pix_o.alpha_out = out_word[3];

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> v_q[0])
    else $error("accepted request did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[LAST] && v_q[LAST-1] && !pix_o.ready |=> v_q[LAST-1])
    else $error("request lost behind a stalled output");

  a_mode_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> mode_q == mode_e'($past(pwdata[1:0])))
    else $error("output_mode write not taken");

endmodule

>>> src/lpef_chan_arith.sv
// lpef_chan_arith: three-stage per-channel front end (decode, scale multiply, round)
// depends on lpef_pkg; feeds lpef_srgb_search

module lpef_chan_arith #(
  parameter int unsigned SRGB_INDEX_BITS = lpef_pkg::SRGB_INDEX_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic [lpef_pkg::ARITH_STAGES-1:0]      en_i,
  input  lpef_pkg::mode_e                        mode_i,
  input  logic                                   alpha_i,
  input  logic [lpef_pkg::WORD_W-1:0]            word_i,
  output lpef_pkg::chan_t                        chan_o
);
  import lpef_pkg::*;

  localparam int unsigned IDX_W  = SRGB_INDEX_BITS;
  localparam int unsigned PROD_W = MANT_W + IDX_W;
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  typedef enum logic [1:0] {OP_UNORM, OP_SRGB, OP_NORMAL, OP_HDR} op_e;

  typedef struct packed {
    op_e               op;
    logic              fixed;
    logic [WORD_W-1:0] fix_word;
    logic              neg;
    logic [MANT_W-1:0] mant;
    logic [SH_W-1:0]   sh;
  } dec_t;

  typedef struct packed {
    op_e               op;
    logic              fixed;
    logic [WORD_W-1:0] fix_word;
    logic              neg;
    logic [PROD_W-1:0] prod;
    logic [SH_W-1:0]   sh;
  } mul_t;

  dec_t s1_d, s1_q;
  mul_t s2_d, s2_q;
  chan_t s3_d, s3_q;

  logic [7:0]        expo;
  logic [22:0]       frac;
  logic              is_nan;
  logic              ge_one;
  logic [7:0]        shift_s;
  logic [IDX_W-1:0]  scale;
  logic [5:0]        rsh;
  logic [5:0]        nsh;
  logic [PROD_W-1:0] rnd;
  logic [PROD_W-1:0] q;
  logic              sticky;
  logic [CODE_W-1:0] ncode;

  // decode
  always_comb begin
    expo    = word_i[30:23];
    frac    = word_i[22:0];
    is_nan  = (expo == 8'hFF) && (frac != '0);
    ge_one  = word_i[30:0] >= FLOAT_ONE[30:0];
    shift_s = (expo != '0) ? (EXP_SHIFT_BASE - expo) : DENORM_SHIFT;

    if (mode_i == MODE_HDR) begin
      s1_d.op = OP_HDR;
    end else if (alpha_i || mode_i == MODE_LINEAR) begin
      s1_d.op = OP_UNORM;
    end else if (mode_i == MODE_SRGB) begin
      s1_d.op = OP_SRGB;
    end else begin
      s1_d.op = OP_NORMAL;
    end

    s1_d.neg  = word_i[31];
    s1_d.mant = (expo != '0) ? {1'b1, frac} : {1'b0, frac};
    s1_d.sh   = (shift_s > SHIFT_CLIP) ? SH_W'(SHIFT_CLIP - SHIFT_MIN)
                                       : SH_W'(shift_s - SHIFT_MIN);
    s1_d.fixed    = 1'b0;
    s1_d.fix_word = '0;

    unique case (s1_d.op)
      OP_HDR: begin
        s1_d.fixed = 1'b1;
        if (is_nan || word_i[31]) begin
          s1_d.fix_word = '0;
        end else begin
          s1_d.fix_word = (word_i > HDR_MAX) ? HDR_MAX : word_i;
        end
      end
      OP_UNORM: begin
        if (is_nan || word_i[31]) begin
          s1_d.fixed = 1'b1;
        end else if (ge_one) begin
          s1_d.fixed    = 1'b1;
          s1_d.fix_word = WORD_W'(UNORM_MAX);
        end
      end
      OP_SRGB: begin
        if (is_nan || word_i[31]) begin
          s1_d.fixed = 1'b1;
        end else if (ge_one) begin
          s1_d.fixed    = 1'b1;
          s1_d.fix_word = WORD_W'(IDX_MAX);
        end
      end
      OP_NORMAL: begin
        if (is_nan) begin
          s1_d.fixed = 1'b1;
        end else if (ge_one) begin
          s1_d.fixed    = 1'b1;
          s1_d.fix_word = word_i[31] ? '0 : WORD_W'(UNORM_MAX);
        end else if (s1_d.mant == '0) begin
          s1_d.fixed    = 1'b1;
          s1_d.fix_word = WORD_W'(NORMAL_MID);
        end
      end
      default: begin
        s1_d.fixed = 1'b1;
      end
    endcase
  end

  // scale multiply
  always_comb begin
    scale         = (s1_q.op == OP_SRGB) ? IDX_MAX : IDX_W'(UNORM_MAX);
    s2_d.op       = s1_q.op;
    s2_d.fixed    = s1_q.fixed;
    s2_d.fix_word = s1_q.fix_word;
    s2_d.neg      = s1_q.neg;
    s2_d.sh       = s1_q.sh;
    s2_d.prod     = PROD_W'(s1_q.mant) * PROD_W'(scale);
  end

  // round to nearest unorm code or srgb index; normal map codes are floored
  always_comb begin
    rsh    = 6'(s2_q.sh) + 6'(SHIFT_MIN - 8'd1);
    nsh    = 6'(s2_q.sh) + 6'(SHIFT_MIN + 8'd1);
    rnd    = ((s2_q.prod >> rsh) + PROD_W'(1)) >> 1;
    q      = s2_q.prod >> nsh;
    sticky = (q << nsh) != s2_q.prod;
    ncode  = s2_q.neg ? (NORMAL_MID - q[CODE_W-1:0] - CODE_W'(sticky))
                      : (NORMAL_MID + q[CODE_W-1:0]);

    s3_d.srgb = (s2_q.op == OP_SRGB);
    if (s2_q.fixed) begin
      s3_d.word = s2_q.fix_word;
    end else if (s2_q.op == OP_NORMAL) begin
      s3_d.word = WORD_W'(ncode);
    end else begin
      s3_d.word = WORD_W'(rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_q <= s1_d;
    end
    if (en_i[1]) begin
      s2_q <= s2_d;
    end
    if (en_i[2]) begin
      s3_q <= s3_d;
    end
  end

  assign chan_o = s3_q;

endmodule

>>> src/lpef_srgb_search.sv
// lpef_srgb_search: four-stage srgb code search, two threshold steps per stage
// depends on lpef_pkg; takes the rounded index from lpef_chan_arith

module lpef_srgb_search #(
  parameter int unsigned SRGB_INDEX_BITS = lpef_pkg::SRGB_INDEX_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic [lpef_pkg::SRCH_STAGES-1:0]  en_i,
  input  lpef_pkg::chan_t                   chan_i,
  output logic [lpef_pkg::WORD_W-1:0]       word_o
);
  import lpef_pkg::*;

  localparam int unsigned     IDX_W    = SRGB_INDEX_BITS;
  localparam longint unsigned IDX_MAX  = (64'd1 << IDX_W) - 64'd1;
  localparam longint unsigned LIN_MAX  = (SRGB_KNEE_NUM * IDX_MAX) / SRGB_KNEE_DEN;
  localparam logic [IDX_W-1:0] LIN_MAX_IDX = IDX_W'(LIN_MAX);
  localparam thr_arr_t THR = srgb_thresholds(IDX_W);

  typedef struct packed {
    logic              srgb;
    logic [IDX_W-1:0]  idx;
    logic [CODE_W-1:0] code;
    logic [WORD_W-1:0] word;
  } srch_t;

  logic [CODE_W-1:0] lin_tab [256];
  srch_t st_d [SRCH_STAGES];
  srch_t st_q [SRCH_STAGES];

  for (genvar i = 0; i < 256; i++) begin : g_lin
    localparam longint unsigned LinVal =
      (SRGB_LIN_NUM * i + SRGB_LIN_HALF * IDX_MAX) / (SRGB_LIN_SCALE * IDX_MAX);
    assign lin_tab[i] = CODE_W'(LinVal);
  end

  function automatic logic [CODE_W-1:0] search_step(input logic [CODE_W-1:0] code,
                                                    input logic [IDX_W-1:0] idx,
                                                    input int unsigned bitpos);
    logic [CODE_W-1:0] cand;
    cand = code | (CODE_W'(1) << bitpos);
    return (thr_t'(idx) >= THR[cand]) ? cand : code;
  endfunction

  always_comb begin
    st_d[0].srgb = chan_i.srgb;
    st_d[0].idx  = chan_i.word[IDX_W-1:0];
    st_d[0].word = chan_i.word;
    if (chan_i.srgb && (chan_i.word[IDX_W-1:0] <= LIN_MAX_IDX)) begin
      st_d[0].srgb = 1'b0;
      st_d[0].word = WORD_W'(lin_tab[chan_i.word[CODE_W-1:0]]);
    end
    st_d[0].code = search_step(search_step('0, st_d[0].idx, CODE_W - 1),
                               st_d[0].idx, CODE_W - 2);
  end

  for (genvar s = 1; s < SRCH_STAGES; s++) begin : g_step
    always_comb begin
      st_d[s]      = st_q[s-1];
      st_d[s].code = search_step(search_step(st_q[s-1].code, st_q[s-1].idx,
                                             CODE_W - 1 - 2 * s),
                                 st_q[s-1].idx, CODE_W - 2 - 2 * s);
    end
  end

  for (genvar s = 0; s < SRCH_STAGES; s++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign word_o = st_q[SRCH_STAGES-1].srgb ? WORD_W'(st_q[SRCH_STAGES-1].code)
                                            : st_q[SRCH_STAGES-1].word;

endmodule

>>> sim/linear_pixel_to_encoder_format_tb.sv
// linear_pixel_to_encoder_format_tb: checks encoded rgba pixels against a bit-exact predictor
// of all four output modes, with random idling, back-pressure and apb mode changes
// depends on lpef_pkg, lpef_if and linear_pixel_to_encoder_format

typedef logic [lpef_pkg::NUM_CHAN-1:0][lpef_pkg::WORD_W-1:0] pixel_t;
typedef logic [319:0] wide_t;

class pixel_scoreboard;
  lpef_pkg::mode_e  enc_mode;
  longint unsigned  srgb_top;
  logic [16:0]      srgb_step [256];
  pixel_t           expected_q [$];
  int unsigned      mismatch_count;

  function new();
    wide_t       curve_c;
    wide_t       top_pow5;
    wide_t       rhs;
    wide_t       lhs;
    int unsigned idx;
    bit          reached;
    enc_mode       = lpef_pkg::MODE_LINEAR;
    mismatch_count = 0;
    srgb_top       = (64'd1 << lpef_pkg::SRGB_INDEX_BITS_DEF) - 64'd1;
    curve_c        = wide_t'(1);
    top_pow5       = wide_t'(1);
    for (int j = 0; j < 12; j++) curve_c = curve_c * wide_t'(lpef_pkg::SRGB_THR_DEN);
    for (int j = 0; j < 5; j++) top_pow5 = top_pow5 * wide_t'(srgb_top);
    // smallest quantised index reaching each code step, walked upward once
    srgb_step[0] = '0;
    idx = 0;
    for (int k = 1; k < 256; k++) begin
      rhs = top_pow5;
      for (int j = 0; j < 12; j++) begin
        rhs = rhs * wide_t'(lpef_pkg::SRGB_THR_STEP * k + lpef_pkg::SRGB_THR_OFS);
      end
      reached = 1'b0;
      while (!reached && idx <= srgb_top) begin
        lhs = curve_c;
        for (int j = 0; j < 5; j++) lhs = lhs * wide_t'(idx);
        if (lhs >= rhs) begin
          reached = 1'b1;
        end else begin
          idx++;
        end
      end
      srgb_step[k] = 17'(idx);
    end
  endfunction

  function bit is_nan(logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] != '0;
  endfunction

  function void split_float(input logic [31:0] b, output longint unsigned mant,
                            output int unsigned shift);
    if (b[30:23] != 8'd0) begin
      mant  = {40'd0, 1'b1, b[22:0]};
      shift = 150 - b[30:23];
    end else begin
      mant  = {41'd0, b[22:0]};
      shift = 149;
    end
  endfunction

  function logic [31:0] unorm_code(logic [31:0] b, longint unsigned scale);
    longint unsigned mant;
    int unsigned     shift;
    if (is_nan(b) || b[31]) return '0;
    if (b >= lpef_pkg::FLOAT_ONE) return 32'(scale);
    split_float(b, mant, shift);
    if (mant == 0 || shift >= 42) return '0;
    return 32'((64'd2 * scale * mant + (64'd1 << shift)) >> (shift + 1));
  endfunction

  function logic [31:0] normal_code(logic [31:0] b);
    longint unsigned mant;
    longint unsigned base;
    int unsigned     shift;
    if (is_nan(b)) return '0;
    if ({1'b0, b[30:0]} >= lpef_pkg::FLOAT_ONE) return b[31] ? 32'd0 : 32'd255;
    split_float(b, mant, shift);
    if (mant == 0) return 32'd128;
    if (shift > 40) return b[31] ? 32'd127 : 32'd128;
    base = 64'd256 << shift;
    if (b[31]) return 32'((base - 64'd255 * mant) >> (shift + 1));
    return 32'((base + 64'd255 * mant) >> (shift + 1));
  endfunction

  function logic [31:0] srgb_code(logic [31:0] b);
    longint unsigned idx;
    int unsigned     code;
    idx = unorm_code(b, srgb_top);
    if (idx * lpef_pkg::SRGB_KNEE_DEN <= lpef_pkg::SRGB_KNEE_NUM * srgb_top) begin
      return 32'((lpef_pkg::SRGB_LIN_NUM * idx + lpef_pkg::SRGB_LIN_HALF * srgb_top) /
                 (lpef_pkg::SRGB_LIN_SCALE * srgb_top));
    end
    code = 0;
    for (int k = 1; k < 256; k++) begin
      if (idx >= srgb_step[k]) code++;
    end
    return code;
  endfunction

  function logic [31:0] encode_channel(logic [31:0] b, int unsigned chan);
    if (enc_mode == lpef_pkg::MODE_HDR) begin
      if (is_nan(b) || b[31]) return '0;
      return (b > lpef_pkg::HDR_MAX) ? lpef_pkg::HDR_MAX : b;
    end
    if (chan == lpef_pkg::ALPHA_CHAN || enc_mode == lpef_pkg::MODE_LINEAR) begin
      return unorm_code(b, 255);
    end
    if (enc_mode == lpef_pkg::MODE_SRGB) return srgb_code(b);
    return normal_code(b);
  endfunction

  function void note_request(pixel_t px);
    pixel_t enc;
    for (int c = 0; c < lpef_pkg::NUM_CHAN; c++) enc[c] = encode_channel(px[c], c);
    expected_q.push_back(enc);
  endfunction

  function void check_result(pixel_t got);
    pixel_t exp_px;
    string  names [4] = '{"red_out", "green_out", "blue_out", "alpha_out"};
    if (expected_q.size() == 0) begin
      $error("result with no pixel pending: %h", got);
      mismatch_count++;
      return;
    end
    exp_px = expected_q.pop_front();
    for (int c = 0; c < lpef_pkg::NUM_CHAN; c++) begin
      if (got[c] !== exp_px[c]) begin
        $error("%s: expected %h, actual %h", names[c], exp_px[c], got[c]);
        mismatch_count++;
      end
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module linear_pixel_to_encoder_format_tb;
  import lpef_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned LONG_HOLD      = 64;
  localparam int unsigned PHASE_ITEMS    = 166;
  localparam int unsigned NUM_CORNERS    = 20;

  localparam logic [31:0] CORNER_VALS [NUM_CORNERS] = '{
    32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000,
    32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001,
    32'h007F_FFFF, 32'h3F00_0000, 32'h3F7F_FFFF, 32'h477F_E000, 32'h477F_E001,
    32'h7F7F_FFFF, 32'h3B4D_2E1C, 32'hBF7F_FFFF, 32'hB680_0000, 32'h3C00_0000
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned        tx_gap_pct;
  int unsigned        rx_gap_pct;
  bit                 long_hold_req;
  int unsigned        fail_count;
  pixel_scoreboard    pix_sb;

  lpef_in_if  pix_in ();
  lpef_out_if pix_out ();

  linear_pixel_to_encoder_format u_dut (
    .clk_i,
    .rst_ni,
    .pix_i   (pix_in),
    .pix_o   (pix_out),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("linear_pixel_to_encoder_format verification failed");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    pix_out.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        pix_out.ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else if (rx_gap_pct != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
        pix_out.ready = 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk_i);
      end else begin
        pix_out.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      pix_sb.check_result({pix_out.alpha_out, pix_out.blue_out,
                           pix_out.green_out, pix_out.red_out});
    end
  end

  function automatic logic [31:0] rand_channel();
    int unsigned pick;
    logic [22:0] mant;
    pick = $urandom_range(0, 99);
    mant = 23'($urandom);
    if (pick < 20) return $urandom;
    if (pick < 35) return {1'b0, 8'($urandom_range(100, 126)), mant};
    if (pick < 50) return {1'b0, 8'($urandom_range(116, 126)), mant};
    if (pick < 62) return {1'b1, 8'($urandom_range(100, 126)), mant};
    if (pick < 70) return {1'($urandom), 8'($urandom_range(0, 111)), mant};
    if (pick < 82) return {1'($urandom), 8'($urandom_range(126, 142)), mant};
    if (pick < 88) return {1'($urandom), 8'hFF, ($urandom_range(0, 1) != 0) ? 23'd0 : mant};
    return CORNER_VALS[$urandom_range(0, NUM_CORNERS - 1)];
  endfunction

  task automatic send_pixel(input pixel_t px);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      @(negedge clk_i);
      pix_in.valid = 1'b0;
      repeat ($urandom_range(1, 17) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    pix_in.valid    = 1'b1;
    pix_in.red_in   = px[0];
    pix_in.green_in = px[1];
    pix_in.blue_in  = px[2];
    pix_in.alpha_in = px[3];
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    pix_sb.note_request(px);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = PADDR_W'({REG_OUTPUT_MODE, 2'b00});
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_mode(input mode_e m);
    logic [31:0] rd;
    @(negedge clk_i);
    pix_in.valid = 1'b0;
    @(posedge clk_i);
    while (pix_sb.pending() != 0) @(posedge clk_i);
    repeat (NUM_STAGES + 2) @(posedge clk_i);
    apb_access(1'b1, 32'(m), rd);
    apb_access(1'b0, '0, rd);
    if (rd[1:0] != 2'(m)) begin
      $error("output_mode: expected %h, actual %h", 2'(m), rd[1:0]);
      fail_count++;
    end
    pix_sb.enc_mode = m;
  endtask

  initial begin
    pixel_t px;
    mode_e  phase_modes [8];
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    pix_in.valid    = 1'b0;
    pix_in.red_in   = '0;
    pix_in.green_in = '0;
    pix_in.blue_in  = '0;
    pix_in.alpha_in = '0;
    tx_gap_pct      = 10;
    rx_gap_pct      = 10;
    long_hold_req   = 1'b0;
    fail_count      = 0;
    pix_sb          = new();
    phase_modes = '{MODE_HDR, MODE_SRGB, MODE_NORMAL, MODE_LINEAR,
                    MODE_NORMAL, MODE_SRGB, MODE_HDR, MODE_SRGB};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // corner values rotated over channels in every mode
    for (int m = 0; m < 4; m++) begin
      set_mode(mode_e'(m));
      for (int j = 0; j < 6; j++) begin
        for (int c = 0; c < NUM_CHAN; c++) begin
          px[c] = CORNER_VALS[(4 * j + c + 3 * m) % NUM_CORNERS];
        end
        send_pixel(px);
      end
    end

    for (int p = 0; p < 8; p++) begin
      set_mode(phase_modes[p]);
      tx_gap_pct = (p == 7) ? 0 : $urandom_range(0, 3) * 8;
      rx_gap_pct = (p == 7) ? 0 : $urandom_range(0, 3) * 8;
      if (p == 2) begin
        tx_gap_pct    = 0;
        long_hold_req = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        for (int c = 0; c < NUM_CHAN; c++) px[c] = rand_channel();
        send_pixel(px);
      end
    end

    @(negedge clk_i);
    pix_in.valid = 1'b0;
    for (int w = 0; w < 1000 && pix_sb.pending() != 0; w++) @(posedge clk_i);
    repeat (2 * NUM_STAGES) @(posedge clk_i);
    if (pix_sb.pending() != 0) begin
      $error("%0d pixels never returned", pix_sb.pending());
    end
    if (fail_count == 0 && pix_sb.mismatch_count == 0 && pix_sb.pending() == 0) begin
      $display("linear_pixel_to_encoder_format verification clean");
    end else begin
      $display("linear_pixel_to_encoder_format verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/lpef_pkg.sv
src/lpef_if.sv
src/lpef_chan_arith.sv
src/lpef_srgb_search.sv
src/linear_pixel_to_encoder_format.sv
sim/linear_pixel_to_encoder_format_tb.sv
